### hdl/bffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg: shared types and constants of the bitmap first-fit allocator
// Widths, register indexes, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // Bitmap geometry
    localparam int NUM_BLOCKS = 256;
    localparam int MAP_IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = MAP_IDX_W + 1;

    // Field widths
    localparam int SIZE_W     = 21;
    localparam int ADDR_W     = 20;
    localparam int BSZ_W      = 13;
    localparam int BIU_W      = 9;
    localparam int CFG_IDX_W  = 8;

    // Divider geometry: dividend holds size plus block size minus one
    localparam int DIVD_W     = SIZE_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);
    localparam int PROD_W     = MAP_IDX_W + BSZ_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = CFG_IDX_W'(1);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_NEED,
        S_FIRST,
        S_CLEAR,
        S_SCAN,
        S_MULT,
        S_CHECK,
        S_MARK,
        S_DONE
    } t_state;

endpackage : bffa_pkg
`default_nettype wire

### hdl/bffa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_div: iterative restoring divider
// Produces one quotient bit per cycle; o_done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module bffa_div
    import bffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [BSZ_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_quo;
    logic [BSZ_W-1:0]     r_rem;
    logic [BSZ_W-1:0]     r_div;

    logic [BSZ_W:0]       rem_sh;
    logic [BSZ_W:0]       diff;
    logic                 ge;
    logic [BSZ_W-1:0]     n_rem;
    logic [DIVD_W-1:0]    n_quo;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        diff   = rem_sh - {1'b0, r_div};
        n_rem  = ge ? diff[BSZ_W-1:0] : rem_sh[BSZ_W-1:0];
        n_quo  = {r_quo[DIVD_W-2:0], ge};
    end

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : bffa_div
`default_nettype wire

### hdl/bitmap_first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator: first-fit block allocator over a bitmap
// Rounds sizes to blocks with a shared divider, scans and updates the bitmap.
// ----------------------------------------------------------------------------
// One word is handled at a time; o_ready is high only while the sequencer is
// idle. Every request first divides by the block size in a bit-serial divider.
// An allocate then scans the bitmap one block per cycle from block 0 until a
// fitting run is found or the managed count is reached, forms and checks the
// byte address in S_MULT and S_CHECK, and marks one block per cycle for the
// blocks it needs. A free runs a second division for the start block, then
// clears one block per cycle. After reset the sequencer clears the bitmap one
// block per cycle, so o_ready first rises once every block is clear;
// configuration writes are always accepted and must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator
    import bffa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_op,
    input  wire logic [SIZE_W-1:0]    i_size,
    input  wire logic [ADDR_W-1:0]    i_start_address,
    // Result channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_ok,
    output logic [ADDR_W-1:0]         o_address,
    // Configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BSZ_W-1:0]     i_cfg_data
);

    t_state                r_state;
    t_state                n_state;

    // Configuration registers
    logic [BSZ_W-1:0]      r_block_size;
    logic [BIU_W-1:0]      r_blocks_in_use;

    // Request and working registers
    logic                  r_op;
    logic [ADDR_W-1:0]     r_start_addr;
    logic [CNT_W-1:0]      r_need;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_run_len;
    logic [MAP_IDX_W-1:0]  r_run_start;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_res_ok;
    logic [ADDR_W-1:0]     r_res_addr;

    logic [CNT_W-1:0]      n_need;
    logic [CNT_W-1:0]      n_idx;
    logic [CNT_W-1:0]      n_run_len;
    logic [MAP_IDX_W-1:0]  n_run_start;
    logic                  n_res_ok;
    logic [ADDR_W-1:0]     n_res_addr;

    // Bitmap
    logic                  r_map [NUM_BLOCKS];
    logic                  r_map_rd;
    logic                  map_we;
    logic                  map_wdata;
    logic                  map_bit;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [ADDR_W-1:0]     r_out_addr;
    logic                  out_load;

    // Divider hookup
    logic                  div_start;
    logic [DIVD_W-1:0]     div_dividend;
    logic                  div_done;
    logic [DIVD_W-1:0]     div_quo;

    logic [BSZ_W-1:0]      bs_eff;
    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      need_sat;
    logic [CNT_W-1:0]      first_sat;
    logic [CNT_W:0]        run_next;
    logic                  in_acc;
    logic                  idx_in_range;

    assign in_acc = i_valid && o_ready;

    // Effective configuration: zero block size acts as one, clamp block count
    always_comb begin
        bs_eff = (r_block_size == '0) ? BSZ_W'(1) : r_block_size;
        if (r_blocks_in_use > BIU_W'(NUM_BLOCKS)) begin
            limit = CNT_W'(NUM_BLOCKS);
        end else begin
            limit = CNT_W'(r_blocks_in_use);
        end
    end

    // Saturate divider results to the bitmap range
    always_comb begin
        if (div_quo[DIVD_W-1:CNT_W] != '0) begin
            need_sat = '1;
        end else begin
            need_sat = div_quo[CNT_W-1:0];
        end
        if (div_quo[DIVD_W-1:MAP_IDX_W] != '0) begin
            first_sat = CNT_W'(NUM_BLOCKS);
        end else begin
            first_sat = {1'b0, div_quo[MAP_IDX_W-1:0]};
        end
    end

    assign map_bit      = r_map_rd;
    assign idx_in_range = (r_idx < limit);
    assign run_next     = {1'b0, r_run_len} + (CNT_W + 1)'(1);

    bffa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_idx == CNT_W'(NUM_BLOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = S_NEED;
            end
            S_NEED: begin
                if (div_done) begin
                    if (r_op == OP_FREE) begin
                        n_state = S_FIRST;
                    end else if (need_sat == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_FIRST: begin
                if (div_done) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                if (r_need == '0 || !idx_in_range) n_state = S_DONE;
            end
            S_SCAN: begin
                if (!idx_in_range) begin
                    n_state = S_DONE;
                end else if (!map_bit && run_next >= {1'b0, r_need}) begin
                    n_state = S_MULT;
                end
            end
            S_MULT:  n_state = S_CHECK;
            S_CHECK: n_state = r_prod[PROD_W-1:ADDR_W] != '0 ? S_DONE : S_MARK;
            S_MARK: begin
                if (r_need == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        n_need       = r_need;
        n_idx        = r_idx;
        n_run_len    = r_run_len;
        n_run_start  = r_run_start;
        n_res_ok     = r_res_ok;
        n_res_addr   = r_res_addr;
        map_we       = 1'b0;
        map_wdata    = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIVD_W'(r_start_addr);
        out_load     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                // Clear one bitmap entry per cycle after reset
                map_we    = 1'b1;
                map_wdata = 1'b0;
                n_idx     = r_idx + CNT_W'(1);
            end
            S_IDLE: begin
                // Start the block count division straight from the input word
                div_start    = in_acc;
                div_dividend = DIVD_W'(i_size) + DIVD_W'(bs_eff - BSZ_W'(1));
                n_res_ok     = 1'b0;
                n_res_addr   = '0;
            end
            S_NEED: begin
                if (div_done) begin
                    n_need      = need_sat;
                    n_idx       = '0;
                    n_run_len   = '0;
                    n_run_start = '0;
                    if (r_op == OP_FREE) begin
                        div_start = 1'b1;
                        n_res_ok  = 1'b1;
                    end else if (need_sat == '0) begin
                        n_res_ok  = 1'b1;
                    end
                end
            end
            S_FIRST: begin
                if (div_done) n_idx = first_sat;
            end
            S_CLEAR: begin
                // Drop one used bit per cycle within the managed range
                if (r_need != '0 && idx_in_range) begin
                    map_we    = 1'b1;
                    map_wdata = 1'b0;
                    n_idx     = r_idx + CNT_W'(1);
                    n_need    = r_need - CNT_W'(1);
                end
            end
            S_SCAN: begin
                // Track the current free run while advancing the cursor
                if (idx_in_range) begin
                    n_idx = r_idx + CNT_W'(1);
                    if (map_bit) begin
                        n_run_len = '0;
                    end else begin
                        if (r_run_len == '0) n_run_start = r_idx[MAP_IDX_W-1:0];
                        n_run_len = run_next[CNT_W-1:0];
                    end
                end
            end
            S_MULT: begin
                n_idx = {1'b0, r_run_start};
            end
            S_CHECK: begin
                if (r_prod[PROD_W-1:ADDR_W] == '0) begin
                    n_res_ok   = 1'b1;
                    n_res_addr = r_prod[ADDR_W-1:0];
                end
            end
            S_MARK: begin
                // Set one used bit per cycle over the granted run
                if (r_need != '0) begin
                    map_we    = 1'b1;
                    map_wdata = 1'b1;
                    n_idx     = r_idx + CNT_W'(1);
                    n_need    = r_need - CNT_W'(1);
                end
            end
            S_DONE: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_INIT;
            r_block_size    <= BSZ_W'(64);
            r_blocks_in_use <= BIU_W'(256);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLOCK_SIZE) begin
                    r_block_size <= i_cfg_data;
                end else if (i_cfg_index == CFG_BLOCKS_IN_USE) begin
                    r_blocks_in_use <= i_cfg_data[BIU_W-1:0];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op         <= i_op;
            r_start_addr <= i_start_address;
        end
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
        r_need      <= n_need;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_res_ok    <= n_res_ok;
        r_res_addr  <= n_res_addr;
        r_prod      <= PROD_W'(r_run_start) * PROD_W'(bs_eff);
    end

    // Bitmap: one bit written and one bit read per cycle; the read follows
    // the next cursor so its registered data lines up with the cursor
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[r_idx[MAP_IDX_W-1:0]] <= map_wdata;
        end
        r_map_rd <= r_map[n_idx[MAP_IDX_W-1:0]];
    end

    // Output register: hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ok   <= r_res_ok;
            r_out_addr <= r_res_addr;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_address   = r_out_addr;
    assign o_cfg_ready = 1'b1;

    // A failed allocation reports address zero
    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_address == '0))
        else $error("failed result carries a nonzero address");

    // Divider completes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_NEED || r_state == S_FIRST))
        else $error("divider finished outside a wait state");

    // Marking stays inside the managed range
    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && r_need != '0) |-> idx_in_range)
        else $error("marking past the managed block count");

    // An accepted word starts the divider and closes the request channel
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (!o_ready && r_state == S_NEED))
        else $error("request channel still open after accept");

endmodule : bitmap_first_fit_block_allocator
`default_nettype wire

### sim/bffa_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_monitor: result checker for the bitmap first-fit block allocator
// Watches the request, result and register channels. It keeps its own block
// map and register copies, works out the answer of every accepted request
// word and compares each result word with the oldest answer still due.
// ----------------------------------------------------------------------------
module bffa_monitor
    import bffa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_ready,
    input  wire logic                 i_req_op,
    input  wire logic [SIZE_W-1:0]    i_req_size,
    input  wire logic [ADDR_W-1:0]    i_req_start,
    // Result channel
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire logic                 i_res_ok,
    input  wire logic [ADDR_W-1:0]    i_res_address,
    // Register channel
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BSZ_W-1:0]     i_cfg_data,
    // Status for the testbench top
    output int                        o_failures,
    output int                        o_pending,
    output int                        o_granted,
    output int                        o_refused,
    output int                        o_freed
);

    localparam logic [BSZ_W-1:0]    RESET_BLOCK_BYTES = BSZ_W'(64);
    localparam logic [BIU_W-1:0]    RESET_MANAGED     = BIU_W'(256);
    localparam longint unsigned     ADDR_MAX          = (64'd1 << ADDR_W) - 1;
    localparam int                  MAX_REPORTS       = 10;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } t_answer;

    logic [NUM_BLOCKS-1:0] used_blocks = '0;
    logic [BSZ_W-1:0]      blk_bytes   = RESET_BLOCK_BYTES;
    logic [BIU_W-1:0]      managed     = RESET_MANAGED;
    t_answer               answers_due[$];
    t_answer               want;
    t_answer               got;
    int                    failures    = 0;
    int                    granted     = 0;
    int                    refused     = 0;
    int                    freed       = 0;

    // Apply one request word to the block map and form its answer
    task automatic serve_request(input logic op, input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] start, output t_answer ans);
        int unsigned     bytes_per_blk;
        int unsigned     span;
        int unsigned     need;
        int unsigned     first_blk;
        int unsigned     run_start;
        int unsigned     run_len;
        int unsigned     k;
        longint unsigned byte_addr;
        bit              found;
        bytes_per_blk = (blk_bytes == '0) ? 1 : 32'(blk_bytes);
        span          = (32'(managed) > NUM_BLOCKS) ? NUM_BLOCKS : 32'(managed);
        need          = (32'(size) + bytes_per_blk - 1) / bytes_per_blk;
        ans           = '0;
        if (op == OP_FREE) begin
            // clear from the block holding the start, stop at the managed count
            first_blk = 32'(start) / bytes_per_blk;
            k = 0;
            while (k < need && first_blk + k < span) begin
                used_blocks[first_blk + k] = 1'b0;
                k++;
            end
            ans.ok = 1'b1;
            freed++;
        end else if (need == 0) begin
            ans.ok = 1'b1;
            granted++;
        end else begin
            // first-fit scan from block 0 upward
            run_start = 0;
            run_len   = 0;
            found     = 1'b0;
            k         = 0;
            while (!found && k < span) begin
                if (used_blocks[k]) begin
                    run_len = 0;
                end else begin
                    if (run_len == 0) begin
                        run_start = k;
                    end
                    run_len++;
                    if (run_len >= need) begin
                        found = 1'b1;
                    end
                end
                k++;
            end
            byte_addr = longint'(run_start) * bytes_per_blk;
            if (found && byte_addr <= ADDR_MAX) begin
                for (k = 0; k < need; k++) begin
                    used_blocks[run_start + k] = 1'b1;
                end
                ans.ok      = 1'b1;
                ans.address = byte_addr[ADDR_W-1:0];
                granted++;
            end else begin
                refused++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            used_blocks = '0;
            blk_bytes   = RESET_BLOCK_BYTES;
            managed     = RESET_MANAGED;
            answers_due.delete();
        end else begin
            // retire the oldest answer against each accepted result word
            if (i_res_valid && i_res_ready) begin
                if (answers_due.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("%0t: result word with nothing due: ok=%0b address=0x%05h",
                                 $realtime, i_res_ok, i_res_address);
                    end
                end else begin
                    want = answers_due.pop_front();
                    if (want.ok !== i_res_ok || want.address !== i_res_address) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display({"%0t: mismatch: expected ok=%0b address=0x%05h,",
                                      " got ok=%0b address=0x%05h"},
                                     $realtime, want.ok, want.address, i_res_ok,
                                     i_res_address);
                        end
                    end
                end
            end
            // track register writes; unknown indexes drop
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLOCK_SIZE: begin
                        blk_bytes = i_cfg_data;
                    end
                    CFG_BLOCKS_IN_USE: begin
                        managed = i_cfg_data[BIU_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // predict each accepted request word
            if (i_req_valid && i_req_ready) begin
                serve_request(i_req_op, i_req_size, i_req_start, got);
                answers_due.push_back(got);
            end
        end
        o_pending  <= answers_due.size();
        o_failures <= failures;
        o_granted  <= granted;
        o_refused  <= refused;
        o_freed    <= freed;
    end

endmodule : bffa_monitor

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the bitmap first-fit block allocator
// Drives directed and random allocate/free words through several register
// settings and idling phases, with one long result hold-off; the monitor
// checks every result word and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bffa_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 600;
    localparam int TAIL_CYCLES     = 600;
    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 80;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 i_op            = OP_ALLOC;
    logic [SIZE_W-1:0]    i_size          = '0;
    logic [ADDR_W-1:0]    i_start_address = '0;
    logic                 i_ready         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_BLOCK_SIZE;
    logic [BSZ_W-1:0]     i_cfg_data      = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_ok;
    logic [ADDR_W-1:0]    o_address;
    logic                 o_cfg_ready;

    int                   failures;
    int                   pending;
    int                   granted;
    int                   refused;
    int                   freed;

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    logic                 hold_req      = 1'b0;
    logic                 hold_served   = 1'b0;
    int                   hold_left     = 0;
    int                   quiet_cycles  = 0;
    int unsigned          cur_bsz       = 64;
    int unsigned          cur_managed   = 256;
    int                   words_sent    = 0;
    int                   settings_seen = 1;

    bitmap_first_fit_block_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_size          (i_size),
        .i_start_address (i_start_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_ok            (o_ok),
        .o_address       (o_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bffa_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_op      (i_op),
        .i_req_size    (i_size),
        .i_req_start   (i_start_address),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res_ok      (o_ok),
        .i_res_address (o_address),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_granted     (granted),
        .o_refused     (refused),
        .o_freed       (freed)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            i_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // Offer one request word after an optional gap; return at its acceptance
    task automatic send_word(input logic op, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] start);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 120) : 0;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_op            <= op;
        i_size          <= size;
        i_start_address <= start;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Drop valid and wait until every answer has come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BSZ_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input int unsigned bsz, input int unsigned biu);
        wait_idle();
        write_reg(CFG_BLOCK_SIZE, BSZ_W'(bsz));
        write_reg(CFG_BLOCKS_IN_USE, BSZ_W'(biu));
        cur_bsz     = bsz;
        cur_managed = biu;
        settings_seen++;
    endtask

    // Mostly block-shaped allocate and free words, some raw noise
    task automatic send_random_word();
        int unsigned bpb;
        int unsigned room;
        int unsigned cap;
        int unsigned blocks;
        int unsigned start_blk;
        int unsigned roll;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] start;
        bpb  = (cur_bsz == 0) ? 1 : cur_bsz;
        room = (cur_managed > NUM_BLOCKS) ? NUM_BLOCKS : cur_managed;
        if (room == 0) begin
            room = 1;
        end
        cap    = (room < 8) ? room : 8;
        blocks = ($urandom_range(9) == 0) ? $urandom_range(1, room) : $urandom_range(1, cap);
        size   = SIZE_W'(blocks * bpb - $urandom_range(bpb - 1));
        roll   = $urandom_range(99);
        if (roll < 6) begin
            send_word(1'($urandom_range(1)), SIZE_W'($urandom), ADDR_W'($urandom));
        end else if (roll < 58) begin
            if ($urandom_range(40) == 0) begin
                size = '0;
            end
            send_word(OP_ALLOC, size, ADDR_W'($urandom));
        end else begin
            start_blk = $urandom_range(room + 1);
            start     = ADDR_W'(start_blk * bpb + $urandom_range(bpb - 1));
            send_word(OP_FREE, size, start);
        end
    endtask

    initial begin
        int          phase;
        int unsigned bsz;
        int unsigned biu;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, 64-byte blocks over 256 blocks
        send_word(OP_ALLOC, 21'd1, '0);
        send_word(OP_ALLOC, 21'd64, '0);
        send_word(OP_ALLOC, 21'd0, '1);
        send_word(OP_ALLOC, '1, '0);
        send_word(OP_ALLOC, 21'd65, '0);
        send_word(OP_FREE, 21'd1, 20'd0);
        send_word(OP_ALLOC, 21'd64, '0);
        send_word(OP_ALLOC, 21'd128, '0);
        send_word(OP_FREE, '1, '1);
        send_word(OP_FREE, 21'd64 * 21'd254, 20'd130);
        send_word(OP_FREE, '1, 20'd0);
        send_word(OP_ALLOC, 21'd16384, '0);
        send_word(OP_ALLOC, 21'd1, '0);
        send_word(OP_FREE, 21'd16384, 20'd0);

        // Widest blocks: the third run lands past the address range
        reconfigure(8191, 256);
        send_word(OP_ALLOC, 21'd128 * 21'd8191, '0);
        send_word(OP_ALLOC, 21'd2 * 21'd8191, '0);
        send_word(OP_ALLOC, 21'd1, '0);
        send_word(OP_FREE, '1, 20'd0);

        // Zero block size acts as one byte; no managed blocks at all
        reconfigure(0, 0);
        send_word(OP_ALLOC, 21'd1, '0);
        send_word(OP_ALLOC, 21'd0, '0);
        send_word(OP_FREE, 21'd5, 20'd0);

        // Three managed blocks; unknown register indexes must be ignored
        reconfigure(0, 3);
        write_reg(CFG_IDX_W'(2), '1);
        write_reg('1, '0);
        send_word(OP_ALLOC, 21'd3, '0);
        send_word(OP_ALLOC, 21'd1, '0);

        // Count above the map size; earlier bits stay used
        reconfigure(0, 511);
        send_word(OP_ALLOC, 21'd2, '0);
        send_word(OP_FREE, '1, 20'd0);

        // Random phases over settings and idling patterns
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin bsz = 64;                      biu = 256; end
                1:       begin bsz = 1;                       biu = 256; end
                2:       begin bsz = 4096;                    biu = 256; end
                3:       begin bsz = 8191;                    biu = 256; end
                4:       begin bsz = 0;                       biu = 64;  end
                5:       begin bsz = $urandom_range(1, 4096); biu = 1;   end
                6:       begin bsz = 16;                      biu = 0;   end
                7:       begin bsz = $urandom_range(1, 4096); biu = 511; end
                9:       begin bsz = 64;                      biu = 32;  end
                10:      begin bsz = 4096;                    biu = 300; end
                default: begin
                    bsz = $urandom_range(1, 4096);
                    biu = $urandom_range(1, 256);
                end
            endcase
            reconfigure(bsz, biu);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
                1:       begin send_idle_pct = 72; stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  stall_pct <= 72; end
                default: begin send_idle_pct = 26; stall_pct <= 26; end
            endcase
            // hold results back while the sender keeps offering
            if (phase == 0) begin
                hold_req <= 1'b1;
            end
            repeat (WORDS_PER_PHASE) send_random_word();
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d request words over %0d register settings", words_sent,
                 settings_seen);
        $display("summary: %0d allocations granted, %0d refused, %0d frees", granted,
                 refused, freed);
        if (failures == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule : tb
